// ----- sv/u8u16_pkg.sv -----
package u8u16_pkg;

   // Queue depth; must leave room for a two-unit item
   localparam int QUEUE_DEPTH = 4;

   // Byte class boundaries
   localparam logic [7:0] BYTE_CONT_MIN  = 8'h80;
   localparam logic [7:0] BYTE_LEAD2_MIN = 8'hC0;
   localparam logic [7:0] BYTE_LEAD3_MIN = 8'hE0;
   localparam logic [7:0] BYTE_LEAD4_MIN = 8'hF0;
   localparam logic [7:0] BYTE_BAD_MIN   = 8'hF8;

   // Code value limits
   localparam logic [20:0] SURR_VALUE_MIN = 21'h00D800;
   localparam logic [20:0] SURR_VALUE_MAX = 21'h00DFFF;
   localparam logic [20:0] SUPP_VALUE_MIN = 21'h010000;
   localparam logic [20:0] CODE_VALUE_MAX = 21'h10FFFF;

   localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
   localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;

   // Units produced by one byte, handed from decoder to queue
   typedef struct packed {
      logic [1:0]  count;
      logic [15:0] unit0;
      logic [15:0] unit1;
   } push_type;

endpackage

// ----- sv/u8u16_decode.sv -----
module u8u16_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          byte_in,
   output u8u16_pkg::push_type push
);

   logic [1:0]  remaining_ff, remaining_in;
   logic [20:0] acc_ff, acc_in;
   logic [20:0] value;
   logic [20:0] offset;
   u8u16_pkg::push_type emit;

   assign value  = {acc_ff[14:0], byte_in[5:0]};
   assign offset = value - u8u16_pkg::SUPP_VALUE_MIN;

   // Units for a completed sequence
   always_comb begin
      emit = '0;
      priority if (value > u8u16_pkg::CODE_VALUE_MAX) begin
         emit.count = 2'd0;
      end else if (value >= u8u16_pkg::SUPP_VALUE_MIN) begin
         emit.count = 2'd2;
         emit.unit0 = u8u16_pkg::SURR_HIGH_BASE + {6'b0, offset[19:10]};
         emit.unit1 = u8u16_pkg::SURR_LOW_BASE + {6'b0, offset[9:0]};
      end else if (value >= u8u16_pkg::SURR_VALUE_MIN &&
                   value <= u8u16_pkg::SURR_VALUE_MAX) begin
         emit.count = 2'd0;
      end else begin
         emit.count = 2'd1;
         emit.unit0 = value[15:0];
      end
   end

   always_comb begin
      push         = '0;
      remaining_in = remaining_ff;
      acc_in       = acc_ff;
      if (accept) begin
         if (remaining_ff != 2'd0) begin
            // inside a sequence every byte is a continuation
            acc_in       = value;
            remaining_in = remaining_ff - 2'd1;
            if (remaining_ff == 2'd1) begin
               push = emit;
            end
         end else begin
            priority if (byte_in == 8'h00) begin
               push.count = 2'd0;
            end else if (byte_in < u8u16_pkg::BYTE_CONT_MIN) begin
               push.count = 2'd1;
               push.unit0 = {8'h00, byte_in};
            end else if (byte_in < u8u16_pkg::BYTE_LEAD2_MIN) begin
               push.count = 2'd0;
            end else if (byte_in < u8u16_pkg::BYTE_LEAD3_MIN) begin
               acc_in       = {16'b0, byte_in[4:0]};
               remaining_in = 2'd1;
            end else if (byte_in < u8u16_pkg::BYTE_LEAD4_MIN) begin
               acc_in       = {17'b0, byte_in[3:0]};
               remaining_in = 2'd2;
            end else if (byte_in < u8u16_pkg::BYTE_BAD_MIN) begin
               acc_in       = {18'b0, byte_in[2:0]};
               remaining_in = 2'd3;
            end else begin
               push.count = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= 2'd0;
      end else begin
         remaining_ff <= remaining_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

// ----- sv/u8u16_outq.sv -----
module u8u16_outq #(
   parameter int DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  u8u16_pkg::push_type push,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [15:0]         rsp_code_unit,
   output logic                rsp_last_of_run
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(DEPTH - 1)) res = '0;
      else res = ptr + 1'b1;
      return res;
   endfunction

   logic [16:0]      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign wr_next         = next_ptr(wr_ptr_ff);
   assign rsp_valid       = (count_ff != '0);
   assign pop             = rsp_valid && !rsp_stall;
   assign rsp_code_unit   = mem_ff[rd_ptr_ff][16:1];
   assign rsp_last_of_run = mem_ff[rd_ptr_ff][0];
   // a two-unit item must always fit
   assign room            = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      unique case (push.count)
         2'd1:    wr_ptr_in = wr_next;
         2'd2:    wr_ptr_in = next_ptr(wr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= {push.unit0, push.count == 2'd1};
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= {push.unit1, 1'b1};
      end
   end

endmodule

// ----- sv/utf8_to_utf16_transcoder.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_byte_in[7:0]
// rsp      out        rsp_valid / rsp_stall  rsp_code_unit[15:0], rsp_last_of_run
//
// One byte per cycle is taken while req_stall is low; its units are written to the
// output queue at that edge and the first can leave in the next cycle. The queue
// drains one unit per cycle while rsp_stall is low; four-byte characters give two.
// req_stall rises when the queue cannot hold two more units.
// Synchronous reset empties the queue and closes any open sequence.
module utf8_to_utf16_transcoder #(
   parameter int QUEUE_DEPTH = u8u16_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_last_of_run
);

   u8u16_pkg::push_type push;
   logic                room;
   logic                accept;

   assign req_stall = !room;
   assign accept    = req_valid && room;

   u8u16_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .byte_in (req_byte_in),
      .push    (push)
   );

   u8u16_outq #(
      .DEPTH (QUEUE_DEPTH)
   ) u_outq (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .room            (room),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- sv/u8u16_checker.sv -----
module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_byte_in,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_code_unit,
   input logic        rsp_last_of_run
);

   logic rsp_take;
   logic high_surr;

   assign rsp_take  = rsp_valid && !rsp_stall;
   assign high_surr = (rsp_code_unit[15:10] == 6'b110110);

   // nothing to deliver right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_code_unit) && $stable(rsp_last_of_run)))
      else $error("stalled rsp item changed");

   // only a high surrogate may leave a run open
   a_open_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !rsp_last_of_run) |-> high_surr)
      else $error("non-final unit is not a high surrogate");

   // high surrogate is followed at once by its low half
   a_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && high_surr) |=>
         (rsp_valid && rsp_code_unit[15:10] == 6'b110111 && rsp_last_of_run))
      else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   localparam int LIMIT        = 50000;
   localparam int RANDOM_ITEMS = 400;

   // Byte classes and code value limits, kept locally for the decoder model
   localparam logic [7:0]  CONT_MIN  = 8'h80;
   localparam logic [7:0]  LEAD2_MIN = 8'hC0;
   localparam logic [7:0]  LEAD3_MIN = 8'hE0;
   localparam logic [7:0]  LEAD4_MIN = 8'hF0;
   localparam logic [7:0]  BAD_MIN   = 8'hF8;
   localparam logic [20:0] SURR_MIN  = 21'h00D800;
   localparam logic [20:0] SURR_MAX  = 21'h00DFFF;
   localparam logic [20:0] SUPP_MIN  = 21'h010000;
   localparam logic [20:0] VALUE_MAX = 21'h10FFFF;
   localparam logic [15:0] HIGH_BASE = 16'hD800;
   localparam logic [15:0] LOW_BASE  = 16'hDC00;

   // One input byte; when fixed is set the units come from the row, not the model
   typedef struct packed {
      logic [7:0]  data;
      logic        drain;
      logic        fixed;
      logic [1:0]  count;
      logic [15:0] unit0;
      logic [15:0] unit1;
   } byte_row_type;

   typedef struct packed {
      logic [15:0] unit;
      logic        last;
   } code_unit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_code_unit;
   logic        rsp_last_of_run;

   byte_row_type   byte_stream[$];
   code_unit_type  pending_units[$];
   byte_row_type   in_flight;
   byte_row_type   directed_rows [26];
   logic        hold_next;
   logic [1:0]  open_conts;
   logic [20:0] code_value;
   int          accepted;
   int          total_bytes;
   int          mismatches;
   int          cycle;

   utf8_to_utf16_transcoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle, what);
      mismatches++;
   endtask

   // Advances the decoder state by one byte; returns how many units it yields
   function automatic int decode_utf8_byte(input logic [7:0] b, output logic [15:0] hi_unit,
                                           output logic [15:0] lo_unit);
      logic [20:0] off;
      hi_unit = 16'h0000;
      lo_unit = 16'h0000;
      if (open_conts != 2'd0) begin
         code_value = {code_value[14:0], b[5:0]};
         open_conts = open_conts - 2'd1;
         if (open_conts != 2'd0) return 0;
         if (code_value > VALUE_MAX) return 0;
         if (code_value >= SUPP_MIN) begin
            off     = code_value - SUPP_MIN;
            hi_unit = HIGH_BASE + 16'(off[19:10]);
            lo_unit = LOW_BASE + 16'(off[9:0]);
            return 2;
         end
         if (code_value >= SURR_MIN && code_value <= SURR_MAX) return 0;
         hi_unit = code_value[15:0];
         return 1;
      end
      if (b == 8'h00) return 0;
      if (b < CONT_MIN) begin
         hi_unit = {8'h00, b};
         return 1;
      end
      if (b < LEAD2_MIN) return 0;
      if (b < LEAD3_MIN) begin
         code_value = {16'h0000, b[4:0]};
         open_conts = 2'd1;
      end else if (b < LEAD4_MIN) begin
         code_value = {17'h00000, b[3:0]};
         open_conts = 2'd2;
      end else if (b < BAD_MIN) begin
         code_value = {18'h00000, b[2:0]};
         open_conts = 2'd3;
      end
      return 0;
   endfunction

   function automatic logic [7:0] cont_byte();
      if ($urandom_range(0, 99) < 85) return {2'b10, 6'($urandom_range(0, 63))};
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_byte(input logic [7:0] b);
      byte_row_type row;
      row       = '0;
      row.data  = b;
      row.drain = hold_next;
      hold_next = 1'b0;
      byte_stream.push_back(row);
   endtask

   task automatic build_random_stream();
      int counted;
      int kind;
      int n;
      logic [7:0] b;
      logic mid_marked;
      counted    = 0;
      mid_marked = 1'b0;
      hold_next  = 1'b1;
      while (counted < RANDOM_ITEMS) begin
         if (counted >= RANDOM_ITEMS / 2 && !mid_marked) begin
            hold_next  = 1'b1;
            mid_marked = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            push_byte(8'($urandom_range(1, 127)));
            counted += 1;
         end else if (kind < 48) begin
            push_byte(8'($urandom_range(8'hC0, 8'hDF)));
            push_byte(cont_byte());
            counted += 2;
         end else if (kind < 66) begin
            // ED leads often land in the surrogate range
            b = ($urandom_range(0, 3) == 0) ? 8'hED : 8'($urandom_range(8'hE0, 8'hEF));
            push_byte(b);
            push_byte(cont_byte());
            push_byte(cont_byte());
            counted += 3;
         end else if (kind < 84) begin
            b = $urandom_range(0, 1) ? 8'($urandom_range(8'hF0, 8'hF4))
                                     : 8'($urandom_range(8'hF0, 8'hF7));
            push_byte(b);
            repeat (3) push_byte(cont_byte());
            counted += 4;
         end else if (kind < 92) begin
            b = 8'($urandom_range(0, 255));
            push_byte(b);
            if ((b >= 8'h01 && b < CONT_MIN) || (b >= LEAD2_MIN && b < BAD_MIN)) counted += 1;
         end else begin
            // lead followed by arbitrary bytes, possibly cut short
            push_byte(8'($urandom_range(8'hC0, 8'hF7)));
            n = $urandom_range(0, 2);
            repeat (n) push_byte(8'($urandom_range(0, 255)));
            counted += 1 + n;
         end
      end
   endtask

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle >= LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result checking and both sides of the handshake, in one process so that
   // expectations are pushed and popped in a fixed order
   always @(posedge clock) begin : bench
      code_unit_type  want;
      logic [15:0] u0;
      logic [15:0] u1;
      int          n;
      logic        calm;
      calm = (accepted >= 150 && accepted < 270);
      if (reset) begin
         req_valid   <= 1'b0;
         req_byte_in <= 8'h00;
         rsp_stall   <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_units.size() == 0) begin
               report_mismatch($sformatf("unit %h with none expected", rsp_code_unit));
            end else begin
               want = pending_units.pop_front();
               if (rsp_code_unit !== want.unit)
                  report_mismatch($sformatf("code_unit %h, want %h", rsp_code_unit, want.unit));
               if (rsp_last_of_run !== want.last)
                  report_mismatch($sformatf("last_of_run %b, want %b on unit %h",
                                            rsp_last_of_run, want.last, want.unit));
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 12);

         if (req_valid && !req_stall) begin
            n = decode_utf8_byte(in_flight.data, u0, u1);
            if (in_flight.fixed) begin
               n  = in_flight.count;
               u0 = in_flight.unit0;
               u1 = in_flight.unit1;
            end
            if (n == 1) pending_units.push_back('{u0, 1'b1});
            if (n == 2) begin
               pending_units.push_back('{u0, 1'b0});
               pending_units.push_back('{u1, 1'b1});
            end
            accepted++;
         end
         if (!(req_valid && req_stall)) begin
            if (byte_stream.size() != 0
                && !(byte_stream[0].drain && pending_units.size() != 0)
                && (calm || $urandom_range(0, 99) >= 12)) begin
               in_flight = byte_stream.pop_front();
               req_valid   <= 1'b1;
               req_byte_in <= in_flight.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   initial begin
      cycle      = 0;
      accepted   = 0;
      mismatches = 0;
      open_conts = 2'd0;
      code_value = 21'd0;
      // data, drain, fixed, count, unit0, unit1
      directed_rows = '{
         '{8'h00, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},  // zero byte dropped
         '{8'h7F, 1'b0, 1'b1, 2'd1, 16'h007F, 16'h0000},
         '{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},  // stray continuation
         '{8'hF8, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},  // invalid lead
         '{8'hC2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
         '{8'hA9, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
         '{8'hEF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'hBF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'hBF, 1'b0, 1'b1, 2'd1, 16'hFFFF, 16'h0000},
         '{8'hED, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},  // encoded surrogate
         '{8'hA0, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'hF4, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},  // top code point
         '{8'h8F, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'hBF, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'hBF, 1'b0, 1'b1, 2'd2, 16'hDBFF, 16'hDFFF},
         '{8'hF4, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},  // just past the top
         '{8'h90, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000, 16'h0000},
         '{8'hF0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},  // overlong 4-byte, one unit
         '{8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
         '{8'h81, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
         '{8'h81, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
         '{8'hC3, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},  // zero taken as continuation
         '{8'h00, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000}
      };
      foreach (directed_rows[i]) byte_stream.push_back(directed_rows[i]);
      build_random_stream();
      total_bytes = byte_stream.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (accepted < total_bytes) @(posedge clock);
      while (pending_units.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/u8u16_pkg.sv
sv/u8u16_decode.sv
sv/u8u16_outq.sv
sv/utf8_to_utf16_transcoder.sv
sv/u8u16_checker.sv
sim/tb_top.sv
